@@ rtl/core/icpl_pkg.sv @@
// ----------------------------------------------------------------------------
// icpl_pkg
// Shared types and constants of the interrupt controller pending logic.
// ----------------------------------------------------------------------------
`default_nettype none

package icpl_pkg;

  // Request types
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  // Register map
  typedef enum logic [2:0] {
    REG_IRQ_PEND = 3'd0,
    REG_MASK     = 3'd1,
    REG_LEVEL    = 3'd2,
    REG_CONTROL  = 3'd3,
    REG_FIQ_PEND = 3'd4,
    REG_PENDING  = 3'd5
  } reg_index_t;

  // Pending word bit positions
  localparam int unsigned GPIO_LOW_TOP = 10;
  localparam int unsigned GPIO_HI_BIT  = 11;
  localparam int unsigned LCD_BIT      = 12;
  localparam int unsigned UART_LSB     = 15;
  localparam int unsigned UART_MSB     = 17;
  localparam int unsigned TIMER_LSB    = 26;
  localparam int unsigned TIMER_MSB    = 29;
  localparam int unsigned RTC_HZ_BIT   = 30;
  localparam int unsigned RTC_ALM_BIT  = 31;

  // Control register: idle mask mode bit
  localparam int unsigned CTRL_DIM_BIT = 0;

  // One request as held in the input register
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [27:0] gpio_edges;
    logic [3:0]  timer_status;
    logic [1:0]  rtc_events;
    logic [2:0]  lcd_flags;
    logic [1:0]  lcd_masks;
    logic [2:0]  uart_irq;
    logic        core_idle;
  } item_t;

  // One result
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        fiq_out;
    logic        wake_core;
    logic        access_error;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/icpl_gather.sv @@
// ----------------------------------------------------------------------------
// icpl_gather
// Folds the source status of a tick request into the pending word.
// ----------------------------------------------------------------------------
`default_nettype none

module icpl_gather
  import icpl_pkg::*;
(
  input  wire item_t       item,
  input  wire logic [31:0] pend_cur,
  output logic      [31:0] pend_new
);

  logic lcd_on;

  // LCD: other flags always, BAU/LDD only when unmasked
  assign lcd_on = item.lcd_flags[2]
                | (item.lcd_flags[0] & ~item.lcd_masks[0])
                | (item.lcd_flags[1] & ~item.lcd_masks[1]);

  // Assemble the new pending word
  always_comb begin
    pend_new = pend_cur;
    // GPIO bits move only when some edge is reported
    if (|item.gpio_edges) begin
      pend_new[GPIO_LOW_TOP:0] = item.gpio_edges[GPIO_LOW_TOP:0];
      pend_new[GPIO_HI_BIT]    = |item.gpio_edges[27:GPIO_HI_BIT];
    end
    pend_new[LCD_BIT]             = lcd_on;
    pend_new[UART_MSB:UART_LSB]   = item.uart_irq;
    pend_new[TIMER_MSB:TIMER_LSB] = item.timer_status;
    pend_new[RTC_HZ_BIT]          = item.rtc_events[1];
    pend_new[RTC_ALM_BIT]         = item.rtc_events[0];
  end

endmodule

`default_nettype wire

@@ rtl/core/icpl_state.sv @@
// ----------------------------------------------------------------------------
// icpl_state
// Controller registers: pending, IRQ/FIQ split, mask, level and control.
// Decodes reads and writes and forms the result of the current request.
// ----------------------------------------------------------------------------
`default_nettype none

module icpl_state
  import icpl_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              exec,
  input  wire item_t       item,
  input  wire logic [31:0] pend_new,
  output logic      [31:0] pend_cur,
  output result_t          res
);

  logic [31:0] pend_r,  pend_nxt;
  logic [31:0] irq_r,   irq_nxt;
  logic [31:0] fiq_r,   fiq_nxt;
  logic [31:0] mask_r,  mask_nxt;
  logic [31:0] level_r, level_nxt;
  logic        dim_r,   dim_nxt;
  logic [31:0] enabled;

  assign pend_cur = pend_r;
  assign enabled  = pend_new & mask_r;

  // Request decode
  always_comb begin
    pend_nxt  = pend_r;
    irq_nxt   = irq_r;
    fiq_nxt   = fiq_r;
    mask_nxt  = mask_r;
    level_nxt = level_r;
    dim_nxt   = dim_r;
    res       = '0;
    unique case (req_type_t'(item.req_type))
      REQ_TICK: begin
        pend_nxt      = pend_new;
        irq_nxt       = enabled & ~level_r;
        fiq_nxt       = enabled & level_r;
        res.wake_core = item.core_idle & (|pend_new) & (~dim_r | (|enabled));
      end
      REQ_READ: begin
        unique case (reg_index_t'(item.reg_index))
          REG_IRQ_PEND: res.read_data = irq_r;
          REG_MASK:     res.read_data = mask_r;
          REG_LEVEL:    res.read_data = level_r;
          REG_CONTROL:  res.read_data = {31'b0, dim_r};
          REG_FIQ_PEND: res.read_data = fiq_r;
          REG_PENDING:  res.read_data = pend_r;
          default:      res.read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (reg_index_t'(item.reg_index))
          REG_MASK:    mask_nxt  = item.write_data;
          REG_LEVEL:   level_nxt = item.write_data;
          REG_CONTROL: dim_nxt   = item.write_data[CTRL_DIM_BIT];
          default:     res.access_error = 1'b1;
        endcase
      end
      default: ;
    endcase
    res.irq_out = |irq_nxt;
    res.fiq_out = |fiq_nxt;
  end

  // State registers, updated once per executed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      irq_r   <= '0;
      fiq_r   <= '0;
      mask_r  <= '0;
      level_r <= '0;
      dim_r   <= 1'b0;
    end else if (exec) begin
      pend_r  <= pend_nxt;
      irq_r   <= irq_nxt;
      fiq_r   <= fiq_nxt;
      mask_r  <= mask_nxt;
      level_r <= level_nxt;
      dim_r   <= dim_nxt;
    end
  end

  // IRQ and FIQ sets never overlap
  a_irq_fiq_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (irq_r & fiq_r) == 32'b0)
    else $error("irq and fiq pending overlap");

  // Routed bits always come from the pending word
  a_routed_in_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ((irq_r | fiq_r) & ~pend_r) == 32'b0)
    else $error("routed interrupt not in pending word");

  // A mask or level write leaves the routed sets alone until the next tick
  a_write_keeps_route: assert property (@(posedge clk) disable iff (!rst_n)
    exec && item.req_type == REQ_WRITE |=> $stable(irq_r) && $stable(fiq_r))
    else $error("write changed routed sets");

endmodule

`default_nettype wire

@@ rtl/core/interrupt_controller_pending_logic.sv @@
// ----------------------------------------------------------------------------
// interrupt_controller_pending_logic
// Interrupt controller pending logic with IRQ/FIQ steering and idle wake.
// ----------------------------------------------------------------------------
// Every request (tick, register read or register write) is held in an input
// register, where the pending word, mask, level split and register decode
// are all worked out, and then sits in the result register until the
// consumer takes it. One request is accepted per cycle while results are
// taken. The input register moves forward whenever the result register
// is empty or being emptied; while a result is held, one more request can
// still enter the input register, and the input stalls once both registers
// are full. Register state changes when a request leaves the input register;
// a mask or level write shows on the IRQ/FIQ sets only at the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_controller_pending_logic
  import icpl_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_req_type,
  input  wire  [2:0]  in_reg_index,
  input  wire  [31:0] in_write_data,
  input  wire  [27:0] in_gpio_edges,
  input  wire  [3:0]  in_timer_status,
  input  wire  [1:0]  in_rtc_events,
  input  wire  [2:0]  in_lcd_flags,
  input  wire  [1:0]  in_lcd_masks,
  input  wire  [2:0]  in_uart_irq,
  input  wire         in_core_idle,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_out,
  output logic        out_fiq_out,
  output logic        out_wake_core,
  output logic        out_access_error
);

  logic        s0_vld_r;
  item_t       s0_item_r;
  logic        o_vld_r;
  result_t     o_res_r;
  logic        adv;
  logic        take;
  logic [31:0] pend_cur;
  logic [31:0] pend_new;
  result_t     res;

  // Handshake: input stage advances when the result slot is free
  assign adv      = s0_vld_r & (~o_vld_r | ~out_stall);
  assign in_stall = s0_vld_r & ~adv;
  assign take     = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (take || adv) begin
      s0_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s0_item_r <= '{req_type:     in_req_type,
                     reg_index:    in_reg_index,
                     write_data:   in_write_data,
                     gpio_edges:   in_gpio_edges,
                     timer_status: in_timer_status,
                     rtc_events:   in_rtc_events,
                     lcd_flags:    in_lcd_flags,
                     lcd_masks:    in_lcd_masks,
                     uart_irq:     in_uart_irq,
                     core_idle:    in_core_idle};
    end
  end

  // Source gathering
  icpl_gather u_gather (
    .item     (s0_item_r),
    .pend_cur (pend_cur),
    .pend_new (pend_new)
  );

  // Register file and decode
  icpl_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .exec     (adv),
    .item     (s0_item_r),
    .pend_new (pend_new),
    .pend_cur (pend_cur),
    .res      (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv || !out_stall) begin
      o_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res_r <= res;
    end
  end

  assign out_valid        = o_vld_r;
  assign out_read_data    = o_res_r.read_data;
  assign out_irq_out      = o_res_r.irq_out;
  assign out_fiq_out      = o_res_r.fiq_out;
  assign out_wake_core    = o_res_r.wake_core;
  assign out_access_error = o_res_r.access_error;

  // A held result must block the input stage
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && out_stall |-> !adv)
    else $error("result register overwritten while held");

  // Wake and error come from different request types
  a_wake_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> !(out_wake_core && out_access_error))
    else $error("wake and access error together");

  // A wake comes from a tick, which returns no read data
  a_wake_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && out_wake_core |-> out_read_data == 32'b0)
    else $error("read data on a wake result");

endmodule

`default_nettype wire
